// ===== src/rn_pkg.sv =====
// Shared types and constants for the rank normalize block.
package rn_pkg;

  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 6;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 8;

  // Value traveling down the chain with its running count of smaller values
  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
  } rn_tok_t;

  // Contents of one cell as seen by its upstream neighbor during drain
  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] rank;
  } rn_slot_t;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_WAIT  = 3'b010,
    ST_DRAIN = 3'b100
  } rn_state_t;

endpackage

// ===== src/rn_cell.sv =====
// One cell of the rank chain: holds a value and its count of smaller set values.
module rn_cell (
  input  logic             clk,
  input  logic             rst,
  input  rn_pkg::rn_tok_t  tok_in,
  output rn_pkg::rn_tok_t  tok_out,
  input  rn_pkg::rn_slot_t nbr,
  input  logic             shift_en,
  output rn_pkg::rn_slot_t slot
);
  import rn_pkg::*;

  logic                      vld;
  logic signed [VALUE_W-1:0] value;
  logic [RANK_W-1:0]         rank;
  logic                      tok_vld;
  logic signed [VALUE_W-1:0] tok_value;
  logic [RANK_W-1:0]         tok_rank;
  logic                      held_lt;
  logic                      tok_lt;

  assign held_lt = value < tok_in.value;
  assign tok_lt  = tok_in.value < value;

  // Settle a word in an empty cell, else compare and bump the larger side's count
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift_en) begin
      vld <= nbr.vld;
    end else if (tok_in.vld && !vld) begin
      vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      rank <= nbr.rank;
    end else if (tok_in.vld) begin
      if (!vld) begin
        value <= tok_in.value;
        rank  <= tok_in.rank;
      end else if (tok_lt) begin
        rank <= rank + RANK_W'(1);
      end
    end
  end

  // Pass the word on to the next cell when this one is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_vld <= 1'b0;
    end else begin
      tok_vld <= tok_in.vld && vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_value <= tok_in.value;
    tok_rank  <= tok_in.rank + RANK_W'(held_lt);
  end

  assign tok_out.vld   = tok_vld;
  assign tok_out.value = tok_value;
  assign tok_out.rank  = tok_rank;

  assign slot.vld  = vld;
  assign slot.rank = rank;

endmodule

// ===== src/rank_normalize.sv =====
// Rank normalize: stream a set of signed values in, stream their ranks out.
//
// Input words on s_axis carry one signed 32-bit value each; tlast marks the
// last value of the set. Each accepted value enters a chain of MAX_ITEMS
// cells and walks down it one cell per cycle, comparing against each held
// value, until it settles in the first free cell. A new value is taken
// every cycle while the set loads. Values that arrive once MAX_ITEMS are
// held are dropped and do not count toward any rank.
// After the marked word, the block waits for the last value to settle, then
// shifts the ranks out of cell 0 on m_axis, one word per cycle, in arrival
// order; tlast marks the last rank. Each rank is the count of held values
// strictly smaller than that value, so equal values share a rank.
// s_axis_tready is low from the marked word until the last rank is taken.
// When the receiver stalls, the current rank holds on m_axis and the chain
// does not shift. Reset empties the chain and makes the block ready for a
// new set; no clearing pass is needed.
module rank_normalize #(
  parameter int MAX_ITEMS = rn_pkg::MAX_ITEMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rn_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [31:0] item_value
  input  logic                           s_axis_tlast,  // final_item
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [5:0] item_rank, [7:6] zero
  output logic                           m_axis_tlast   // final_rank
);
  import rn_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  rn_state_t          state;
  rn_state_t          state_next;
  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   remaining;
  rn_tok_t            tok_chain [MAX_ITEMS+1];
  rn_slot_t           slots     [MAX_ITEMS+1];
  logic               in_acc;
  logic               out_acc;
  logic               has_room;
  logic               busy;

  assign s_axis_tready = (state == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign has_room      = held < CNT_W'(MAX_ITEMS);

  // Inject an accepted word at the head of the chain when there is room
  assign tok_chain[0].vld   = in_acc && has_room;
  assign tok_chain[0].value = s_axis_tdata;
  assign tok_chain[0].rank  = '0;

  assign slots[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rn_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_chain[i]),
      .tok_out  (tok_chain[i+1]),
      .nbr      (slots[i+1]),
      .shift_en (out_acc),
      .slot     (slots[i])
    );
  end

  // Flag any word still walking the chain
  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= MAX_ITEMS; i++) begin
      busy = busy | tok_chain[i].vld;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_acc && s_axis_tlast) state_next = ST_WAIT;
      ST_WAIT:  if (!busy) state_next = ST_DRAIN;
      ST_DRAIN: if (out_acc && remaining == CNT_W'(1)) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Track the set size and the ranks left to send
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      held      <= '0;
      remaining <= '0;
    end else begin
      state <= state_next;
      if (in_acc && has_room) begin
        held <= held + CNT_W'(1);
      end
      if (state == ST_WAIT) begin
        remaining <= held;
      end else if (out_acc) begin
        remaining <= remaining - CNT_W'(1);
        if (remaining == CNT_W'(1)) begin
          held <= '0;
        end
      end
    end
  end

  assign m_axis_tvalid = (state == ST_DRAIN);
  assign m_axis_tdata  = OUT_DATA_W'(slots[0].rank);
  assign m_axis_tlast  = (remaining == CNT_W'(1));

endmodule

// ===== src/rn_checker.sv =====
// Port-level checks for the rank normalize block, bound to the top level.
module rn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import rn_pkg::*;

  // Loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while ranks are being sent");

  // Reset leaves no rank on the output
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("rank word valid right after reset");

  // The marked rank ends the set and reopens the input
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not ready after last rank");

  // A marked input word closes the input until the ranks go out
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after final value");

  // A stalled rank word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("rank word changed while stalled");

endmodule

bind rank_normalize rn_checker u_rn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb.sv =====
// Self-checking testbench for rank_normalize: streams value sets and checks every rank word.
module tb;
  import rn_pkg::*;

  localparam int SET_CAP    = MAX_ITEMS_DEF;
  localparam int MAX_CYCLES = 200000;

  // One expected output word: rank of a stored value and the end-of-set mark
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              is_last;
  } rank_word_t;

  typedef enum int {
    VAL_FULL,
    VAL_TIES,
    VAL_EDGES
  } value_mix_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] item_value
  logic                  s_axis_tlast;   // final_item
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [5:0] item_rank, [7:6] zero
  logic                  m_axis_tlast;   // final_rank

  // Predictor state: values of the set being loaded, ranks still to arrive
  logic signed [VALUE_W-1:0] held_values[$];
  rank_word_t                expected_ranks[$];
  logic signed [VALUE_W-1:0] outgoing[$];
  rank_word_t                exp_word;
  int                        smaller;

  int  mismatches    = 0;
  int  words_in      = 0;
  int  sets_done     = 0;
  int  ranks_checked = 0;
  int  cycle_count   = 0;
  bit  idle_on       = 1'b1;
  int  hold_off      = 0;
  int  stall_left    = 0;

  rank_normalize #(
    .MAX_ITEMS(SET_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d ranks pending", $time, cycle_count,
               expected_ranks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: long hold-off on request, else short random stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_axis_tready = 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left    = $urandom_range(1, 5) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Check each rank word, then fold each accepted value into the predicted set
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_ranks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected rank word, expected none, actual data %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          exp_word = expected_ranks.pop_front();
          ranks_checked++;
          if (m_axis_tdata !== {{(OUT_DATA_W-RANK_W){1'b0}}, exp_word.rank}) begin
            mismatches++;
            $display("%0t: rank mismatch, expected %0d, actual data %h", $time,
                     exp_word.rank, m_axis_tdata);
          end
          if (m_axis_tlast !== exp_word.is_last) begin
            mismatches++;
            $display("%0t: last mark mismatch, expected %b, actual %b", $time,
                     exp_word.is_last, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_in++;
        // drop values beyond capacity
        if (held_values.size() < SET_CAP)
          held_values.push_back($signed(s_axis_tdata));
        if (s_axis_tlast) begin
          foreach (held_values[k]) begin
            smaller = 0;
            foreach (held_values[j])
              if (held_values[j] < held_values[k])
                smaller++;
            exp_word.rank    = smaller[RANK_W-1:0];
            exp_word.is_last = (k == held_values.size() - 1);
            expected_ranks.push_back(exp_word);
          end
          held_values.delete();
          sets_done++;
        end
      end
    end
  end

  // Drive one word and hold it until accepted
  task automatic send_word(input logic [IN_DATA_W-1:0] value, input logic mark);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tlast  = mark;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Send the queued set, marking its last word, then release the bus
  task automatic send_set();
    foreach (outgoing[i])
      send_word(outgoing[i], i == outgoing.size() - 1);
    outgoing.delete();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(input value_mix_t mix);
    logic [VALUE_W-1:0] v;
    case (mix)
      VAL_TIES: v = $urandom_range(0, 6) - 3;
      VAL_EDGES: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
      end
      default:  v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random_set(input int count, input value_mix_t mix);
    repeat (count) outgoing.push_back(pick_value(mix));
    send_set();
  endtask

  // Wait until every predicted rank has been seen
  task automatic wait_idle();
    @(posedge clk);
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_single_values();
    outgoing.push_back(32'h8000_0000);
    send_set();
    outgoing.push_back(32'h7FFF_FFFF);
    send_set();
    outgoing.push_back(32'h0000_0000);
    send_set();
    wait_idle();
  endtask

  task automatic test_ties_and_order();
    // extremes with repeats
    outgoing = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1};
    send_set();
    // all equal
    outgoing = '{-32'sd7, -32'sd7, -32'sd7, -32'sd7};
    send_set();
    // ascending, then descending
    outgoing = '{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
    send_set();
    outgoing = '{32'sd100, 32'sd50, 32'sd0, -32'sd50, -32'sd100};
    send_set();
    wait_idle();
  endtask

  // Fill the set, then send one extra plain word and a marked word; both drop
  task automatic test_overflow();
    send_random_set(SET_CAP + 2, VAL_FULL);
    wait_idle();
  endtask

  // Hold the receiver off while the sender keeps offering the next set
  task automatic test_backpressure();
    hold_off = 250;
    send_random_set(10, VAL_TIES);
    send_random_set(6, VAL_FULL);
    wait_idle();
  endtask

  // Pause the sender until all ranks are back, then go on
  task automatic test_sender_pause();
    send_random_set(5, VAL_EDGES);
    wait_idle();
    send_random_set(4, VAL_FULL);
    wait_idle();
  endtask

  task automatic test_random_sets(input int budget);
    int         sent;
    int         count;
    value_mix_t mix;
    sent = 0;
    while (sent < budget) begin
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
      mix   = value_mix_t'($urandom_range(0, 2));
      send_random_set(count, mix);
      sent += count;
    end
    wait_idle();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_single_values();
    test_ties_and_order();
    test_overflow();
    test_backpressure();
    test_sender_pause();
    test_random_sets(70);
    // close with no idling on either side
    idle_on = 1'b0;
    test_random_sets(30);

    repeat (SET_CAP + 16) @(posedge clk);
    $display("Run covered %0d input words in %0d sets, including overflow and backpressure;",
             words_in, sets_done);
    $display("%0d rank words checked, %0d mismatches", ranks_checked, mismatches);
    if (mismatches == 0 && expected_ranks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== rank_normalize.f =====
src/rn_pkg.sv
src/rn_cell.sv
src/rank_normalize.sv
src/rn_checker.sv
sim/tb.sv
